// File: hdl/dsh_pkg.sv
package dsh_pkg;

    // Fixed formats: heights Q15.8, amplitude Q10.8
    localparam int H_W    = 24;
    localparam int SUM_W  = 26;
    localparam int AMP_W  = 18;
    localparam int OFF_W  = 20;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 10;

    localparam logic [CFG_W-1:0] START_AMP_RESET = 10'd300;

    // Reciprocals of three: exact floor for operands below 2^25 and 2^19
    localparam logic [23:0] RECIP3_SUM = 24'hAAAAAB;
    localparam int          RECIP3_SUM_SH = 25;
    localparam logic [18:0] RECIP3_AMP = 19'h2AAAB;
    localparam int          RECIP3_AMP_SH = 19;

    localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [H_W-1:0] H_MIN = 24'sh800000;

    // Pass codes
    localparam logic [1:0] PH_CENTRE = 2'd0;
    localparam logic [1:0] PH_ROW    = 2'd1;
    localparam logic [1:0] PH_COL    = 2'd2;

    // Per-point control travelling from the front to the back
    typedef struct packed {
        logic signed [OFF_W-1:0] offset;   // displacement less a third of amplitude
        logic                    three;    // average over three neighbours
        logic                    done;     // last point of the map
        logic                    first;    // first point of the map
        logic [3:0]              nb_use;   // neighbour is stored (not a corner, in map)
    } dsh_ctl_t;

endpackage

// File: hdl/dsh_ram.sv
module dsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 66049,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read-first: a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/dsh_fifo.sv
module dsh_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/dsh_front.sv
module dsh_front #(
    parameter int SIDE_LOG2 = 8,
    localparam int CW   = SIDE_LOG2 + 1,
    localparam int SIDE = (1 << SIDE_LOG2) + 1,
    localparam int AW   = $clog2(SIDE * SIDE)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dsh_pkg::CFG_W-1:0]         start_amplitude,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dsh_pkg::FRAC_W-1:0]        s_noise_fraction,
    input  logic                              s_restart,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [CW-1:0]                     push_row,
    output logic [CW-1:0]                     push_col,
    output logic [AW-1:0]                     push_addr,
    output logic [3:0][AW-1:0]                push_nb,
    output dsh_pkg::dsh_ctl_t                 push_ctl
);

    localparam logic [CW-1:0] N0   = CW'(1 << (SIDE_LOG2 - 1));
    localparam logic [CW-1:0] LAST = CW'(SIDE - 1);
    localparam logic [CW:0]   SIDE_X = (CW+1)'(SIDE);

    logic [CW-1:0]                half_reg, half_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [CW-1:0]                row_reg, row_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [dsh_pkg::AMP_W-1:0]    amp_reg, amp_next;
    logic                         first_reg, first_next;

    logic [CW-1:0]                n, r, c, n_half;
    logic [1:0]                   ph;
    logic [dsh_pkg::AMP_W-1:0]    amp;
    logic [CW:0]                  r_plus, c_plus, r_step, c_step;
    logic [CW-1:0]                rm, rp, cm, cp;
    logic                         r_lo_ok, r_hi_ok, c_lo_ok, c_hi_ok;
    logic [3:0][CW-1:0]           nr, nc;
    logic [3:0]                   nb_ok;
    logic                         three, done, accept;
    logic [33:0]                  disp_prod;
    logic [36:0]                  third_prod;
    logic [dsh_pkg::AMP_W-1:0]    disp, third;

    function automatic logic is_corner(input logic [CW-1:0] rr, input logic [CW-1:0] cc);
        is_corner = ((rr == '0) || (rr == LAST)) && ((cc == '0) || (cc == LAST));
    endfunction

    function automatic logic [AW-1:0] lin_addr(input logic [CW-1:0] rr,
                                               input logic [CW-1:0] cc);
        lin_addr = AW'({rr, {SIDE_LOG2{1'b0}}}) + AW'(rr) + AW'(cc);
    endfunction

    assign accept     = s_valid && push_ready;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // Restart overrides the cursor with a fresh map
    always_comb begin
        if (s_restart) begin
            n   = N0;
            ph  = dsh_pkg::PH_CENTRE;
            r   = N0;
            c   = N0;
            amp = {start_amplitude, 8'b0};
        end else begin
            n   = half_reg;
            ph  = phase_reg;
            r   = row_reg;
            c   = col_reg;
            amp = amp_reg;
        end
    end

    assign r_plus  = {1'b0, r} + {1'b0, n};
    assign c_plus  = {1'b0, c} + {1'b0, n};
    assign r_lo_ok = (r >= n);
    assign c_lo_ok = (c >= n);
    assign r_hi_ok = (r_plus < SIDE_X);
    assign c_hi_ok = (c_plus < SIDE_X);
    assign rm      = r - n;
    assign cm      = c - n;
    assign rp      = r_plus[CW-1:0];
    assign cp      = c_plus[CW-1:0];

    always_comb begin
        case (ph)
            dsh_pkg::PH_CENTRE: begin
                nr = {rp, rp, rm, rm};
                nc = {cm, cp, cp, cm};
                nb_ok = {r_hi_ok && c_lo_ok, r_hi_ok && c_hi_ok,
                         r_lo_ok && c_hi_ok, r_lo_ok && c_lo_ok};
                three = 1'b0;
            end
            dsh_pkg::PH_ROW: begin
                nr = {rp, rm, r, r};
                nc = {c, c, cm, cp};
                nb_ok = {r_hi_ok, r_lo_ok, c_lo_ok, c_hi_ok};
                three = !r_lo_ok || !r_hi_ok;
            end
            default: begin
                nr = {r, r, rp, rm};
                nc = {cp, cm, c, c};
                nb_ok = {c_hi_ok, c_lo_ok, r_hi_ok, r_lo_ok};
                three = !c_lo_ok || !c_hi_ok;
            end
        endcase
    end

    assign disp_prod  = 34'(s_noise_fraction) * 34'(amp);
    assign third_prod = 37'(amp) * 37'(dsh_pkg::RECIP3_AMP);
    assign disp       = disp_prod[33:16];
    assign third      = third_prod[dsh_pkg::RECIP3_AMP_SH +: dsh_pkg::AMP_W];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            push_nb[i]         = lin_addr(nr[i], nc[i]);
            push_ctl.nb_use[i] = nb_ok[i] && !is_corner(nr[i], nc[i]);
        end
        push_ctl.offset = $signed({2'b00, disp}) - $signed({2'b00, third});
        push_ctl.three  = three;
        push_ctl.done   = done;
        push_ctl.first  = s_restart || first_reg;
    end

    assign push_row        = r;
    assign push_col        = c;
    assign push_addr       = lin_addr(r, c);

    // Advance the cursor: columns inner, rows outer, then pass, then level
    assign c_step = {1'b0, c} + ({1'b0, n} << 1);
    assign r_step = {1'b0, r} + ({1'b0, n} << 1);
    assign n_half = n >> 1;

    always_comb begin
        half_next  = n;
        phase_next = ph;
        row_next   = r;
        col_next   = c;
        amp_next   = amp;
        first_next = 1'b0;
        done       = 1'b0;
        if (c_step < SIDE_X) begin
            col_next = c_step[CW-1:0];
        end else begin
            col_next = (ph == dsh_pkg::PH_COL) ? '0 : n;
            if (r_step < SIDE_X) begin
                row_next = r_step[CW-1:0];
            end else begin
                case (ph)
                    dsh_pkg::PH_CENTRE: begin
                        phase_next = dsh_pkg::PH_ROW;
                        row_next   = '0;
                        col_next   = n;
                    end
                    dsh_pkg::PH_ROW: begin
                        phase_next = dsh_pkg::PH_COL;
                        row_next   = n;
                        col_next   = '0;
                    end
                    default: begin
                        if (n_half == '0) begin
                            done       = 1'b1;
                            half_next  = N0;
                            phase_next = dsh_pkg::PH_CENTRE;
                            row_next   = N0;
                            col_next   = N0;
                            amp_next   = {start_amplitude, 8'b0};
                            first_next = 1'b1;
                        end else begin
                            half_next  = n_half;
                            phase_next = dsh_pkg::PH_CENTRE;
                            row_next   = n_half;
                            col_next   = n_half;
                            amp_next   = amp >> 1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= N0;
            phase_reg <= dsh_pkg::PH_CENTRE;
            row_reg   <= N0;
            col_reg   <= N0;
            amp_reg   <= {dsh_pkg::START_AMP_RESET, 8'b0};
            first_reg <= 1'b1;
        end else if (accept) begin
            half_reg  <= half_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            amp_reg   <= amp_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: hdl/dsh_back.sv
module dsh_back #(
    parameter int SIDE_LOG2 = 8,
    localparam int CW   = SIDE_LOG2 + 1,
    localparam int SIDE = (1 << SIDE_LOG2) + 1,
    localparam int AW   = $clog2(SIDE * SIDE)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    output logic                            head_ready,
    input  logic [CW-1:0]                   head_row,
    input  logic [CW-1:0]                   head_col,
    input  logic [AW-1:0]                   head_addr,
    input  logic [3:0][AW-1:0]              head_nb,
    input  dsh_pkg::dsh_ctl_t               head_ctl,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [CW-1:0]                   m_row,
    output logic [CW-1:0]                   m_column,
    output logic signed [dsh_pkg::H_W-1:0]  m_point_height,
    output logic                            m_map_done,
    output logic signed [dsh_pkg::H_W-1:0]  m_lowest_height,
    output logic signed [dsh_pkg::H_W-1:0]  m_highest_height
);

    localparam int HW = dsh_pkg::H_W;
    localparam int SW = dsh_pkg::SUM_W;

    logic                 adv, issue, hazard;
    logic [1:0]           k_reg;
    logic [AW-1:0]        rd_addr;
    logic [HW-1:0]        rd_data;
    logic                 ram_we;

    // Read stage
    logic                 v1_reg, use1_reg, first1_reg, last1_reg;
    logic [CW-1:0]        row1_reg, col1_reg;
    logic [AW-1:0]        addr1_reg;
    dsh_pkg::dsh_ctl_t    ctl1_reg;
    logic signed [SW-1:0] acc_reg, acc_next, term;

    // Divide stage
    logic                 v2_reg;
    logic [CW-1:0]        row2_reg, col2_reg;
    logic [AW-1:0]        addr2_reg;
    dsh_pkg::dsh_ctl_t    ctl2_reg;
    logic signed [SW-1:0] sum2_reg, sum4;
    logic [SW-1:0]        mag;
    logic [48:0]          prod3;
    logic [HW-1:0]        q3;
    logic signed [HW-1:0] avg;

    // Finish stage
    logic                 v3_reg;
    logic [CW-1:0]        row3_reg, col3_reg;
    logic [AW-1:0]        addr3_reg;
    dsh_pkg::dsh_ctl_t    ctl3_reg;
    logic signed [HW-1:0] avg3_reg, h;
    logic signed [HW:0]   hsum;
    logic signed [HW-1:0] min_reg, max_reg, min_next, max_next;

    logic                 m_valid_reg;
    logic [CW-1:0]        m_row_reg, m_col_reg;
    logic signed [HW-1:0] m_h_reg;
    logic                 m_done_reg;

    assign adv = !m_valid_reg || m_ready;

    // Hold a read whose point is still on its way to the store
    assign rd_addr = head_nb[k_reg];
    assign hazard  = head_ctl.nb_use[k_reg] &&
                     ((v1_reg && last1_reg && addr1_reg == rd_addr) ||
                      (v2_reg && addr2_reg == rd_addr) ||
                      (v3_reg && addr3_reg == rd_addr));
    assign issue      = adv && head_valid && !hazard;
    assign head_ready = issue && (k_reg == 2'd3);

    dsh_ram #(
        .WIDTH (HW),
        .DEPTH (SIDE * SIDE)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr3_reg),
        .wdata (h),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            if (issue) begin
                k_reg <= k_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && last1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Accumulate neighbours as they return from the store
    assign term     = use1_reg ? SW'($signed(rd_data)) : '0;
    assign acc_next = (first1_reg ? '0 : acc_reg) + term;

    always_ff @(posedge aclk) begin
        if (adv) begin
            use1_reg   <= head_ctl.nb_use[k_reg];
            first1_reg <= (k_reg == 2'd0);
            last1_reg  <= (k_reg == 2'd3);
            if (issue && k_reg == 2'd3) begin
                row1_reg  <= head_row;
                col1_reg  <= head_col;
                addr1_reg <= head_addr;
                ctl1_reg  <= head_ctl;
            end
            if (v1_reg) begin
                acc_reg <= acc_next;
            end
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            addr2_reg <= addr1_reg;
            ctl2_reg  <= ctl1_reg;
            sum2_reg  <= acc_next;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            addr3_reg <= addr2_reg;
            ctl3_reg  <= ctl2_reg;
            avg3_reg  <= avg;
        end
    end

    // Average, truncated toward zero
    assign mag   = sum2_reg[SW-1] ? SW'(-sum2_reg) : SW'(sum2_reg);
    assign prod3 = 49'(mag[24:0]) * 49'(dsh_pkg::RECIP3_SUM);
    assign q3    = prod3[dsh_pkg::RECIP3_SUM_SH +: HW];
    assign sum4  = sum2_reg + (sum2_reg[SW-1] ? SW'(3) : SW'(0));

    always_comb begin
        if (ctl2_reg.three) begin
            avg = sum2_reg[SW-1] ? -$signed(q3) : $signed(q3);
        end else begin
            avg = sum4[SW-1:2];
        end
    end

    // Displace, saturate, store and emit
    assign hsum = (HW+1)'(avg3_reg) + (HW+1)'(ctl3_reg.offset);
    assign h    = (hsum[HW] != hsum[HW-1]) ? (hsum[HW] ? dsh_pkg::H_MIN : dsh_pkg::H_MAX)
                                           : hsum[HW-1:0];
    assign ram_we   = adv && v3_reg;
    assign min_next = (ctl3_reg.first || h < min_reg) ? h : min_reg;
    assign max_next = (ctl3_reg.first || h > max_reg) ? h : max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ram_we) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            m_row_reg  <= row3_reg;
            m_col_reg  <= col3_reg;
            m_h_reg    <= h;
            m_done_reg <= ctl3_reg.done;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_row            = m_row_reg;
    assign m_column         = m_col_reg;
    assign m_point_height   = m_h_reg;
    assign m_map_done       = m_done_reg;
    assign m_lowest_height  = min_reg;
    assign m_highest_height = max_reg;

    a_no_read_of_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && head_ctl.nb_use[k_reg] && ram_we) |-> (rd_addr != addr3_reg))
        else $error("neighbour read collides with store write");

    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !adv) |=> v3_reg)
        else $error("finished point lost during output stall");

    a_slot_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        !issue |=> $stable(k_reg))
        else $error("read slot moved without a read");

    a_done_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_map_done) |-> (m_column == CW'(SIDE - 1)))
        else $error("map end flagged away from the last column");

endmodule

// File: hdl/diamond_square_heightmap_top.sv
// Path: an accepted word passes the queue, its four neighbour reads, the read,
// divide and finish stages and the output register.
// Reads: a word's four neighbour reads take turns on the height store's read
// port, and the next word's reads begin while the one before is being finished;
// a read is held while its neighbour is still being written (only near the
// start of a map, where a point reads the point accepted just before it).
// Reset: cursor, amplitude and handshakes clear at once; no clearing pass.
module diamond_square_heightmap_top #(
    parameter int SIDE_LOG2 = 8,
    localparam int CW = SIDE_LOG2 + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: start amplitude, whole height units
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsh_pkg::CFG_W-1:0]       cfg_start_amplitude,
    // one word per point: random fraction and restart
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dsh_pkg::FRAC_W-1:0]      s_noise_fraction,
    input  logic                            s_restart,
    // one word per computed point
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [CW-1:0]                   m_row,
    output logic [CW-1:0]                   m_column,
    output logic signed [dsh_pkg::H_W-1:0]  m_point_height,
    output logic                            m_map_done,
    output logic signed [dsh_pkg::H_W-1:0]  m_lowest_height,
    output logic signed [dsh_pkg::H_W-1:0]  m_highest_height
);

    localparam int SIDE  = (1 << SIDE_LOG2) + 1;
    localparam int AW    = $clog2(SIDE * SIDE);
    localparam int CTL_W = $bits(dsh_pkg::dsh_ctl_t);
    localparam int QW    = 2 * CW + 5 * AW + CTL_W;

    logic [dsh_pkg::CFG_W-1:0] start_amp_reg;

    logic                f_valid, f_ready;
    logic [CW-1:0]       f_row, f_col;
    logic [AW-1:0]       f_addr;
    logic [3:0][AW-1:0]  f_nb;
    dsh_pkg::dsh_ctl_t   f_ctl;

    logic                b_valid, b_ready;
    logic [QW-1:0]       b_data;
    logic [CW-1:0]       b_row, b_col;
    logic [AW-1:0]       b_addr;
    logic [3:0][AW-1:0]  b_nb;
    dsh_pkg::dsh_ctl_t   b_ctl;

    // The register is always writable; the front samples it at each map start,
    // so a write takes effect from the map after the one already begun.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_amp_reg <= dsh_pkg::START_AMP_RESET;
        end else if (cfg_valid) begin
            start_amp_reg <= cfg_start_amplitude;
        end
    end

    // Front: walk the level, pass, row and column order; work out the point,
    // its neighbours' addresses and which of them are stored, and the
    // displacement. Corners and points outside the map are flagged and read
    // as zero; every other neighbour has been written earlier in the map,
    // which is why the store needs no clearing after reset.
    dsh_front #(
        .SIDE_LOG2 (SIDE_LOG2)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start_amplitude  (start_amp_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_noise_fraction (s_noise_fraction),
        .s_restart        (s_restart),
        .push_valid       (f_valid),
        .push_ready       (f_ready),
        .push_row         (f_row),
        .push_col         (f_col),
        .push_addr        (f_addr),
        .push_nb          (f_nb),
        .push_ctl         (f_ctl)
    );

    // Short queue: lets the front keep taking words while the back reads
    dsh_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_row, f_col, f_addr, f_nb, f_ctl}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_row, b_col, b_addr, b_nb, b_ctl} = b_data;

    // Back: four neighbour reads, accumulate, divide, displace and saturate,
    // write the point back and hold it in the output register.
    dsh_back #(
        .SIDE_LOG2 (SIDE_LOG2)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (b_valid),
        .head_ready       (b_ready),
        .head_row         (b_row),
        .head_col         (b_col),
        .head_addr        (b_addr),
        .head_nb          (b_nb),
        .head_ctl         (b_ctl),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_row            (m_row),
        .m_column         (m_column),
        .m_point_height   (m_point_height),
        .m_map_done       (m_map_done),
        .m_lowest_height  (m_lowest_height),
        .m_highest_height (m_highest_height)
    );

endmodule

// File: bench/tb_diamond_square_heightmap_top.sv
module tb_diamond_square_heightmap_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Keep the block at its default size
    localparam int SIDE_LOG2   = 8;
    localparam int CW          = SIDE_LOG2 + 1;
    localparam int SIDE        = (1 << SIDE_LOG2) + 1;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 40;

    typedef struct packed {
        logic [CW-1:0]                  row;
        logic [CW-1:0]                  column;
        logic signed [dsh_pkg::H_W-1:0] height;
        logic                           done;
        logic signed [dsh_pkg::H_W-1:0] lowest;
        logic signed [dsh_pkg::H_W-1:0] highest;
    } point_t;

    typedef struct packed {
        logic [dsh_pkg::FRAC_W-1:0] frac;
        logic                       restart;
        logic                       typed;   // expected word written out below
        point_t                     want;
    } stim_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dsh_pkg::CFG_W-1:0]      cfg_start_amplitude = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [dsh_pkg::FRAC_W-1:0]     s_noise_fraction = '0;
    logic                           s_restart = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [CW-1:0]                  m_row;
    logic [CW-1:0]                  m_column;
    logic signed [dsh_pkg::H_W-1:0] m_point_height;
    logic                           m_map_done;
    logic signed [dsh_pkg::H_W-1:0] m_lowest_height;
    logic signed [dsh_pkg::H_W-1:0] m_highest_height;

    diamond_square_heightmap_top #(.SIDE_LOG2(SIDE_LOG2)) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_start_amplitude (cfg_start_amplitude),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_noise_fraction    (s_noise_fraction),
        .s_restart           (s_restart),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_row               (m_row),
        .m_column            (m_column),
        .m_point_height      (m_point_height),
        .m_map_done          (m_map_done),
        .m_lowest_height     (m_lowest_height),
        .m_highest_height    (m_highest_height)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Height map predictor: own copy of the store, cursor and amplitude
    // ------------------------------------------------------------------
    int     map_heights [SIDE*SIDE];
    int     amp_setting;
    int     half;
    int     phase_code;
    int     cur_row;
    int     cur_col;
    longint amp_q8;
    int     map_low;
    int     map_high;

    point_t pending_points[$];
    int     fail_count = 0;
    int     quiet_cycles = 0;

    // Idle percentages for each side; the hold flag forces a long receiver stall
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     recv_hold = 1'b0;

    function automatic longint height_at(longint r, longint c);
        if (r < 0 || c < 0 || r >= SIDE || c >= SIDE)
            return 0;
        return map_heights[r*SIDE + c];
    endfunction

    // Start a fresh map: full amplitude, extremes cleared, store kept
    function automatic void open_map();
        half       = (SIDE - 1) / 2;
        phase_code = dsh_pkg::PH_CENTRE;
        cur_row    = half;
        cur_col    = half;
        amp_q8     = longint'(amp_setting) << 8;
        map_low    = dsh_pkg::H_MAX;
        map_high   = dsh_pkg::H_MIN;
    endfunction

    function automatic point_t compute_point(logic [dsh_pkg::FRAC_W-1:0] frac,
                                             logic restart);
        point_t p;
        longint r, c, n, total, avg, h;
        bit     done;
        done = 1'b0;
        if (restart)
            open_map();
        r = cur_row;
        c = cur_col;
        n = half;
        if (phase_code == dsh_pkg::PH_CENTRE) begin
            total = height_at(r-n, c-n) + height_at(r-n, c+n) +
                    height_at(r+n, c+n) + height_at(r+n, c-n);
            avg = total / 4;
        end else if (phase_code == dsh_pkg::PH_ROW) begin
            total = height_at(r, c+n) + height_at(r, c-n);
            if (r - n < 0)
                avg = (total + height_at(r+n, c)) / 3;
            else if (r + n >= SIDE)
                avg = (total + height_at(r-n, c)) / 3;
            else
                avg = (total + height_at(r-n, c) + height_at(r+n, c)) / 4;
        end else begin
            total = height_at(r-n, c) + height_at(r+n, c);
            if (c - n < 0)
                avg = (total + height_at(r, c+n)) / 3;
            else if (c + n >= SIDE)
                avg = (total + height_at(r, c-n)) / 3;
            else
                avg = (total + height_at(r, c-n) + height_at(r, c+n)) / 4;
        end
        h = avg + ((longint'(frac) * amp_q8) >>> 16) - (amp_q8 / 3);
        if (h > dsh_pkg::H_MAX) h = dsh_pkg::H_MAX;
        if (h < dsh_pkg::H_MIN) h = dsh_pkg::H_MIN;
        map_heights[r*SIDE + c] = int'(h);
        if (h < map_low)  map_low  = int'(h);
        if (h > map_high) map_high = int'(h);

        p.row     = r[CW-1:0];
        p.column  = c[CW-1:0];
        p.height  = h[dsh_pkg::H_W-1:0];
        p.lowest  = map_low[dsh_pkg::H_W-1:0];
        p.highest = map_high[dsh_pkg::H_W-1:0];

        // advance along the pass, then to the next pass, then down a level
        cur_col += 2 * half;
        if (cur_col >= SIDE) begin
            cur_col = (phase_code == dsh_pkg::PH_COL) ? 0 : half;
            cur_row += 2 * half;
            if (cur_row >= SIDE) begin
                if (phase_code == dsh_pkg::PH_CENTRE) begin
                    phase_code = dsh_pkg::PH_ROW;
                    cur_row = 0;
                    cur_col = half;
                end else if (phase_code == dsh_pkg::PH_ROW) begin
                    phase_code = dsh_pkg::PH_COL;
                    cur_row = half;
                    cur_col = 0;
                end else begin
                    half   = half >> 1;
                    amp_q8 = amp_q8 >> 1;
                    if (half == 0) begin
                        done = 1'b1;
                    end else begin
                        phase_code = dsh_pkg::PH_CENTRE;
                        cur_row = half;
                        cur_col = half;
                    end
                end
            end
        end
        p.done = done;
        if (done)
            open_map();
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Directed words. At reset amplitude 300 the top centre point from zero
    // corners is -25600 (a third of 300.0 in Q.8, displacement zero).
    // ------------------------------------------------------------------
    localparam point_t CENTRE_LOW = '{row: 128, column: 128, height: -25600, done: 1'b0,
                                      lowest: -25600, highest: -25600};
    localparam point_t NO_POINT = '0;

    stim_t directed [16] = '{
        '{16'h0000, 1'b0, 1'b1, CENTRE_LOW},
        '{16'h0000, 1'b1, 1'b1, CENTRE_LOW},   // restart hits the same centre
        '{16'hFFFF, 1'b0, 1'b0, NO_POINT},
        '{16'h8000, 1'b0, 1'b0, NO_POINT},
        '{16'h0001, 1'b0, 1'b0, NO_POINT},
        '{16'hFFFE, 1'b0, 1'b0, NO_POINT},
        '{16'h0000, 1'b1, 1'b1, CENTRE_LOW},
        '{16'h1234, 1'b0, 1'b0, NO_POINT},
        '{16'hFFFF, 1'b0, 1'b0, NO_POINT},
        '{16'h0000, 1'b0, 1'b0, NO_POINT},
        '{16'h5555, 1'b0, 1'b0, NO_POINT},
        '{16'hAAAA, 1'b0, 1'b0, NO_POINT},
        '{16'h0000, 1'b1, 1'b1, CENTRE_LOW},
        '{16'hFFFF, 1'b0, 1'b0, NO_POINT},
        '{16'h7FFF, 1'b0, 1'b0, NO_POINT},
        '{16'h8001, 1'b0, 1'b0, NO_POINT}
    };

    // ------------------------------------------------------------------
    // Sender: present a word, hold it until taken, then maybe go idle
    // ------------------------------------------------------------------
    task automatic send_word(logic [dsh_pkg::FRAC_W-1:0] frac, logic restart, logic typed,
                             point_t want);
        point_t p;
        s_valid          <= 1'b1;
        s_noise_fraction <= frac;
        s_restart        <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        p = compute_point(frac, restart);
        pending_points.insert(pending_points.size(), typed ? want : p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
    endtask

    task automatic send_random(int count, int restart_pct);
        repeat (count)
            send_word(16'($urandom), $urandom_range(99) < restart_pct, 1'b0, NO_POINT);
        s_valid <= 1'b0;
    endtask

    // Write the amplitude only once every outstanding point has come back
    task automatic write_amplitude(logic [dsh_pkg::CFG_W-1:0] value);
        while (pending_points.size() != 0)
            @(posedge aclk);
        cfg_valid           <= 1'b1;
        cfg_start_amplitude <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        amp_setting = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver: drive ready, check each word taken against the oldest point
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected word: row %0d column %0d", m_row, m_column);
                fail_count++;
            end else begin
                point_t w;
                w = pending_points.pop_front();
                if (m_row !== w.row) begin
                    $error("row: expected %0d, actual %0d", w.row, m_row);
                    fail_count++;
                end
                if (m_column !== w.column) begin
                    $error("column: expected %0d, actual %0d", w.column, m_column);
                    fail_count++;
                end
                if (m_point_height !== w.height) begin
                    $error("point_height: expected %0d, actual %0d", w.height,
                           m_point_height);
                    fail_count++;
                end
                if (m_map_done !== w.done) begin
                    $error("map_done: expected %0d, actual %0d", w.done, m_map_done);
                    fail_count++;
                end
                if (m_lowest_height !== w.lowest) begin
                    $error("lowest_height: expected %0d, actual %0d", w.lowest,
                           m_lowest_height);
                    fail_count++;
                end
                if (m_highest_height !== w.highest) begin
                    $error("highest_height: expected %0d, actual %0d", w.highest,
                           m_highest_height);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        amp_setting = dsh_pkg::START_AMP_RESET;
        foreach (map_heights[i])
            map_heights[i] = 0;
        open_map();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender light, receiver heavy
        send_idle_pct = 11;
        recv_idle_pct = 69;
        foreach (directed[i])
            send_word(directed[i].frac, directed[i].restart, directed[i].typed,
                      directed[i].want);
        s_valid <= 1'b0;

        // largest amplitude, taken up at the next restart
        write_amplitude(10'd1023);
        send_random(700, 2);

        // swap the idling, then zero amplitude
        send_idle_pct = 69;
        recv_idle_pct = 11;
        write_amplitude(10'd0);
        send_random(700, 2);

        // no idling; hold the receiver off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_amplitude(10'($urandom_range(1023)));
        fork
            begin
                recv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        send_random(600, 1);

        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0 && pending_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
